### rtl/zcst_pkg.sv
// Shared constants and types for the zero-crossing symbol timing block.
package zcst_pkg;

    localparam int SAMPLE_BITS_DEF = 16;

    localparam int PHASE_W  = 32;
    localparam int STEP_W   = 31;
    localparam int GAIN_W   = 16;
    localparam int THRESH_W = 15;
    localparam int CFG_W    = 31;
    localparam int CFG_AW   = 2;

    localparam logic [CFG_AW-1:0] REG_PHASE_STEP      = 2'd0;
    localparam logic [CFG_AW-1:0] REG_NUDGE_GAIN      = 2'd1;
    localparam logic [CFG_AW-1:0] REG_SLICE_THRESHOLD = 2'd2;

    localparam logic [STEP_W-1:0]   PHASE_STEP_RST      = 31'd536870912;
    localparam logic [GAIN_W-1:0]   NUDGE_GAIN_RST      = 16'd58982;
    localparam logic [THRESH_W-1:0] SLICE_THRESHOLD_RST = 15'd3277;

    // Updated phase state plus the symbol strobe for one sample.
    typedef struct packed {
        logic [PHASE_W-1:0] acc;
        logic [PHASE_W-1:0] acc_prev;
        logic               emit;
    } phase_upd_t;

endpackage

### rtl/zcst_phase.sv
// Phase accumulator update: wrap test, gain nudge and step advance.
module zcst_phase
    import zcst_pkg::*;
(
    input  logic [PHASE_W-1:0] acc,
    input  logic [PHASE_W-1:0] acc_prev,
    input  logic [STEP_W-1:0]  step,
    input  logic [GAIN_W-1:0]  gain,
    input  logic               nudge,
    output phase_upd_t         upd
);

    localparam int PROD_W = PHASE_W + GAIN_W + 1;
    localparam int SUM_W  = PROD_W + 1;

    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  corr;
    logic signed [SUM_W-1:0]  scaled;
    logic signed [SUM_W-1:0]  scaled_step;

    always_comb begin
        prod = $signed(acc) * $signed({1'b0, gain});
        // bias negative products so the shift truncates toward zero
        corr = prod[PROD_W-1] ? SUM_W'(signed'({1'b0, {GAIN_W{1'b1}}})) : '0;
        scaled = SUM_W'(prod) + corr;
        // adding step << 16 before the shift equals adding step after it
        scaled_step = SUM_W'(prod) + corr
                    + SUM_W'(signed'({1'b0, step, {GAIN_W{1'b0}}}));

        upd.emit = acc[PHASE_W-1] && !acc_prev[PHASE_W-1] && (acc_prev != '0);
        if (nudge) begin
            upd.acc_prev = scaled[GAIN_W +: PHASE_W];
            upd.acc      = scaled_step[GAIN_W +: PHASE_W];
        end else begin
            upd.acc_prev = acc;
            upd.acc      = acc + PHASE_W'(step);
        end
    end

endmodule

### rtl/zero_crossing_symbol_timing.sv
// Top level of the zero-crossing symbol timing recovery block.
// A sample is held in in_sample_reg, then loaded into out_symbol_reg, which drives m_tdata.
// Samples are taken one per cycle while the output is not held; the phase accumulator
// loop (one multiply, one add) is combinational, so samples stream without gaps.
// A held result stalls the input after one more sample fills the input stage.
// Reset (aresetn low, synchronous) clears phase, slicer state and valid flags,
// and restores the register defaults.
module zero_crossing_symbol_timing
    import zcst_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
)(
    input  logic              aclk,
    input  logic              aresetn,
    // configuration write port
    input  logic              cfg_wen,
    input  logic [CFG_AW-1:0] cfg_waddr,
    input  logic [CFG_W-1:0]  cfg_wdata,
    // sample stream in
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,    // [SAMPLE_BITS-1:0] sample_in, rest unused
    // symbol stream out
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata     // [SAMPLE_BITS-1:0] symbol_out, rest zero
);

    // compare width covers both the sample and the threshold with a sign bit
    localparam int CMP_W = ((SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W) + 1;

    // configuration registers
    logic [STEP_W-1:0]      phase_step_reg;
    logic [GAIN_W-1:0]      nudge_gain_reg;
    logic [THRESH_W-1:0]    slice_threshold_reg;

    // input stage
    logic                   in_valid_reg, in_valid_next;
    logic [SAMPLE_BITS-1:0] in_sample_reg;

    // timing state
    logic [PHASE_W-1:0]     phase_acc_reg, phase_before_reg;
    logic [SAMPLE_BITS-1:0] last_sample_reg;
    logic                   slice_now_reg, slice_now_next;
    logic                   slice_before_reg, slice_before_next;

    // output stage
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] out_symbol_reg;

    logic                   out_free;
    logic                   fire;
    logic                   s_accept;
    logic signed [CMP_W-1:0] thr_pos, thr_neg, cur_ext, last_ext;
    phase_upd_t             upd;

    // Advance the work stage whenever the output slot is empty or being drained.
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_W'(out_symbol_reg);

    // Register writes: drop unknown indexes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg      <= PHASE_STEP_RST;
            nudge_gain_reg      <= NUDGE_GAIN_RST;
            slice_threshold_reg <= SLICE_THRESHOLD_RST;
        end else if (cfg_wen) begin
            unique case (cfg_waddr)
                REG_PHASE_STEP:      phase_step_reg      <= cfg_wdata[STEP_W-1:0];
                REG_NUDGE_GAIN:      nudge_gain_reg      <= cfg_wdata[GAIN_W-1:0];
                REG_SLICE_THRESHOLD: slice_threshold_reg <= cfg_wdata[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // Hysteresis slicers: go high above +threshold, low below -threshold,
    // hold on or inside the band.
    always_comb begin
        thr_pos  = CMP_W'(signed'({1'b0, slice_threshold_reg}));
        thr_neg  = -thr_pos;
        cur_ext  = CMP_W'($signed(in_sample_reg));
        last_ext = CMP_W'($signed(last_sample_reg));

        slice_now_next = slice_now_reg;
        if (cur_ext > thr_pos)
            slice_now_next = 1'b1;
        else if (cur_ext < thr_neg)
            slice_now_next = 1'b0;

        slice_before_next = slice_before_reg;
        if (last_ext > thr_pos)
            slice_before_next = 1'b1;
        else if (last_ext < thr_neg)
            slice_before_next = 1'b0;
    end

    // A decision mismatch marks a zero crossing and nudges the phase.
    zcst_phase u_phase (
        .acc      (phase_acc_reg),
        .acc_prev (phase_before_reg),
        .step     (phase_step_reg),
        .gain     (nudge_gain_reg),
        .nudge    (slice_now_next != slice_before_next),
        .upd      (upd)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = upd.emit;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // Control and timing state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            phase_acc_reg    <= '0;
            phase_before_reg <= '0;
            last_sample_reg  <= '0;
            slice_now_reg    <= 1'b0;
            slice_before_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire) begin
                phase_acc_reg    <= upd.acc;
                phase_before_reg <= upd.acc_prev;
                last_sample_reg  <= in_sample_reg;
                slice_now_reg    <= slice_now_next;
                slice_before_reg <= slice_before_next;
            end
        end
    end

    // Payload: capture the request, load the symbol on a wrap.
    always_ff @(posedge aclk) begin
        if (s_accept)
            in_sample_reg <= s_tdata[SAMPLE_BITS-1:0];
        if (fire && upd.emit)
            out_symbol_reg <= in_sample_reg;
    end

endmodule

### rtl/zcst_checker.sv
// Port-level checker for the zero-crossing symbol timing block, with its bind.
module zcst_checker
    import zcst_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
)(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata
);

    // A stalled symbol holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled symbol changed or dropped");

    // Reset empties the output stage.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("symbol valid right after reset");

    // Input backpressure only while a symbol waits on the output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // An empty output stage never stalls the input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind zero_crossing_symbol_timing zcst_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_zcst_checker (.*);

### sim/testbench.sv
// Testbench for zero_crossing_symbol_timing: directed and random samples checked against a local timing model.
`timescale 1ns / 1ps

module testbench;
    import zcst_pkg::*;

    localparam int SW          = SAMPLE_BITS_DEF;
    localparam int DW          = ((SW + 7) / 8) * 8;
    localparam int LATENCY     = 2;
    localparam int SETTLE      = 4 * LATENCY;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_SHOWN   = 10;
    localparam int RAND_ITEMS  = 165;
    // Index 3 decodes to no register; writes there must change nothing.
    localparam logic [CFG_AW-1:0] REG_UNUSED = 2'd3;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_wen   = 1'b0;
    logic [CFG_AW-1:0] cfg_waddr = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [DW-1:0]     s_tdata   = '0;    // [15:0] sample_in
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [DW-1:0]     m_tdata;           // [15:0] symbol_out

    zero_crossing_symbol_timing DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_waddr (cfg_waddr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Timing model state and its copy of the registers.
    logic [PHASE_W-1:0]   phase_acc_q;
    logic [PHASE_W-1:0]   phase_prev_q;
    logic signed [SW-1:0] prev_sample_q;
    logic                 dec_now_q;
    logic                 dec_prev_q;
    logic [STEP_W-1:0]    step_q;
    logic [GAIN_W-1:0]    gain_q;
    logic [THRESH_W-1:0]  thresh_q;

    logic [SW-1:0] symbols_due[$];
    logic [SW-1:0] due_symbol;
    int errors            = 0;
    int cycle_count       = 0;
    int idle_pct          = 0;
    int stall_pct         = 0;

    function automatic void reset_timing_model();
        step_q        = PHASE_STEP_RST;
        gain_q        = NUDGE_GAIN_RST;
        thresh_q      = SLICE_THRESHOLD_RST;
        phase_acc_q   = '0;
        phase_prev_q  = '0;
        prev_sample_q = '0;
        dec_now_q     = 1'b0;
        dec_prev_q    = 1'b0;
    endfunction

    // Hysteresis slicer: a sample inside the dead band, edges included, keeps the decision.
    function automatic logic slice_decision(input logic signed [SW-1:0] smp, input logic held);
        int s;
        int thr;
        s   = smp;
        thr = int'(thresh_q);
        if (s > thr) return 1'b1;
        if (s < -thr) return 1'b0;
        return held;
    endfunction

    // Advance the timing loop by one sample; queue the symbol when the phase wraps.
    function automatic void advance_timing(input logic signed [SW-1:0] smp);
        longint prod;
        logic   d_now;
        logic   d_prev;
        // Wrap means negative now and strictly positive one sample earlier.
        if ($signed(phase_acc_q) < 0 && $signed(phase_prev_q) > 0) begin
            symbols_due.insert(symbols_due.size(), smp);
        end
        d_now      = slice_decision(smp, dec_now_q);
        d_prev     = slice_decision(prev_sample_q, dec_prev_q);
        dec_now_q  = d_now;
        dec_prev_q = d_prev;
        // Zero crossing: pull the phase toward zero, truncating toward zero.
        if (d_now != d_prev) begin
            prod        = longint'($signed(phase_acc_q)) * longint'(gain_q);
            prod        = prod / 65536;
            phase_acc_q = prod[PHASE_W-1:0];
        end
        prev_sample_q = smp;
        phase_prev_q  = phase_acc_q;
        phase_acc_q   = phase_acc_q + PHASE_W'(step_q);
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= MAX_SHOWN) $display("%s", msg);
    endtask

    // Drain the symbol stream with a randomly stalled tready and check each symbol in order.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (symbols_due.size() == 0) begin
                flag_error($sformatf("symbol %0d with none pending",
                                     $signed(m_tdata[SW-1:0])));
            end else begin
                due_symbol = symbols_due.pop_front();
                if (m_tdata[SW-1:0] !== due_symbol)
                    flag_error($sformatf("symbol_out: expected %0d, got %0d",
                                         $signed(due_symbol), $signed(m_tdata[SW-1:0])));
            end
        end
        m_tready <= ($urandom_range(99, 0) >= stall_pct);
    end

    // Hard stop in case the handshake hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Send one sample request; keep tvalid high when the next one follows at once.
    task automatic send_sample(input logic [SW-1:0] smp);
        if ($urandom_range(99, 0) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99, 0) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DW'(smp);
        do @(posedge aclk); while (!s_tready);
        advance_timing(smp);
    endtask

    // Hold off the sender until every pending symbol is out and the pipeline is empty.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (symbols_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_register(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wen   <= 1'b1;
        cfg_waddr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        case (idx)
            REG_PHASE_STEP:      step_q   = val[STEP_W-1:0];
            REG_NUDGE_GAIN:      gain_q   = val[GAIN_W-1:0];
            REG_SLICE_THRESHOLD: thresh_q = val[THRESH_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Reset defaults: samples on and just past both threshold edges, plus full scale.
    task automatic test_default_slicing();
        int vals[] = '{0, 3277, 3278, 3277, -3277, -3278, -3277, 32767, -32768, 3278, 0};
        idle_pct  = 0;
        stall_pct = 0;
        foreach (vals[i]) send_sample(SW'(vals[i]));
        wait_idle();
    endtask

    // Zero step: phase moves only on crossings, so no symbol may appear.
    task automatic test_zero_step();
        int vals[] = '{20000, -20000, 20000, -20000, 0, 20000};
        set_register(REG_PHASE_STEP, '0);
        set_register(REG_NUDGE_GAIN, CFG_W'(16'hFFFF));
        foreach (vals[i]) send_sample(SW'(vals[i]));
        wait_idle();
    endtask

    // Register extremes, junk above the gain and threshold widths, and a write to no register.
    task automatic test_register_extremes();
        int vals_a[] = '{1, -1, 0, 1, 5, -5};
        int vals_b[] = '{32767, -32768, -32767, 32767};
        set_register(REG_PHASE_STEP, CFG_W'(32'h7FFF_FFFF));
        set_register(REG_NUDGE_GAIN, {15'h7FFF, 16'h0000});
        set_register(REG_SLICE_THRESHOLD, {16'hFFFF, 15'h0000});
        set_register(REG_UNUSED, CFG_W'($urandom()));
        foreach (vals_a[i]) send_sample(SW'(vals_a[i]));
        wait_idle();
        set_register(REG_PHASE_STEP, CFG_W'(1));
        set_register(REG_NUDGE_GAIN, CFG_W'(16'hFFFF));
        set_register(REG_SLICE_THRESHOLD, CFG_W'(15'h7FFF));
        set_register(REG_UNUSED, '1);
        foreach (vals_b[i]) send_sample(SW'(vals_b[i]));
        wait_idle();
    endtask

    // One random phase: fresh settings, then mostly symbol-shaped waveforms with noise
    // and a share of raw random samples.
    task automatic test_random_phase(input int src_idle, input int sink_stall,
                                     input bit pause_midway);
        int sent;
        int sps;
        int hold_left;
        int level;
        int val;
        logic [STEP_W-1:0]   step;
        logic [GAIN_W-1:0]   gain;
        logic [THRESH_W-1:0] thr;
        logic [CFG_W-1:0]    junk;

        sps  = $urandom_range(16, 2);
        step = (sps == 2) ? '1 : STEP_W'((64'd1 << 32) / sps);
        if ($urandom_range(9, 0) == 0) step = STEP_W'($urandom_range(32'h7FFF_FFFF, 1));
        case ($urandom_range(5, 0))
            0:       gain = '0;
            1:       gain = '1;
            default: gain = GAIN_W'($urandom_range(65535, 32768));
        endcase
        case ($urandom_range(5, 0))
            0:       thr = '0;
            1:       thr = '1;
            default: thr = THRESH_W'($urandom_range(8000, 0));
        endcase
        set_register(REG_PHASE_STEP, CFG_W'(step));
        junk                 = CFG_W'($urandom());
        junk[GAIN_W-1:0]     = gain;
        set_register(REG_NUDGE_GAIN, junk);
        junk                 = CFG_W'($urandom());
        junk[THRESH_W-1:0]   = thr;
        set_register(REG_SLICE_THRESHOLD, junk);

        idle_pct    = src_idle;
        stall_pct   = sink_stall;
        sent        = 0;
        hold_left   = 0;
        level       = 0;
        while (sent < RAND_ITEMS) begin
            if (pause_midway && sent == RAND_ITEMS / 2) wait_idle();
            if (hold_left == 0) begin
                hold_left = sps;
                level     = $urandom_range(32768, 1500);
                if ($urandom_range(1, 0)) level = -level;
            end
            hold_left--;
            if ($urandom_range(99, 0) < 75) begin
                val = level + int'($urandom_range(4000, 0)) - 2000;
                if (val > 32767) val = 32767;
                if (val < -32768) val = -32768;
                send_sample(SW'(val));
            end else begin
                send_sample(SW'($urandom()));
            end
            sent++;
        end
        wait_idle();
    endtask

    initial begin
        reset_timing_model();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_slicing();
        test_zero_step();
        test_register_extremes();
        test_random_phase(0, 0, 1'b1);
        test_random_phase(81, 0, 1'b0);
        test_random_phase(0, 81, 1'b0);
        test_random_phase(31, 31, 1'b0);

        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

### sim.f
rtl/zcst_pkg.sv
rtl/zcst_phase.sv
rtl/zero_crossing_symbol_timing.sv
rtl/zcst_checker.sv
sim/testbench.sv
